/* hw/rtl/stt_pkg.sv */
`default_nettype none

package stt_pkg;

  // Table size and counter width.
  localparam int NUM_TASKS     = 16;
  localparam int INTERVAL_BITS = 16;
  localparam int SLOT_W        = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Fixed field widths of the stream payload.
  localparam int OP_W        = 3;
  localparam int IVAL_W      = 16;
  localparam int KIND_W      = 2;
  localparam int ID_W        = 10;
  localparam int FIRE_SLOT_W = 4;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;

  // Task ids are the slot number plus this base; 11 bits hold base plus table size.
  localparam int ID_CMP_W = 11;
  localparam logic [ID_CMP_W-1:0] ID_BASE  = ID_CMP_W'(1000);
  localparam logic [ID_CMP_W-1:0] ID_LIMIT = ID_CMP_W'(1000 + NUM_TASKS);
  localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(NUM_TASKS - 1);

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ONE_SHOT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CYCLIC    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ONCE_KILL = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd2;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;      // carry out the operation of the accepted beat
  } stt_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/software_timer_task_table_top.sv */
// Software timer task table: a cooperative scheduler for NUM_TASKS task slots.
// Input stream: one beat is one operation. in_tuser carries the opcode (clear,
// create, tick, check, set interval); in_tdata carries its operands.
// Result stream: exactly one beat per operation, in order, with the created
// task id, the fire flag and slot of a check, and a status code.
// Latency: the result beat is valid in the cycle after the input beat is
// accepted. Throughput: one operation per cycle while results are taken; each
// operation is done in a single pass of the datapath, with tick decrementing
// active nonzero counters at once and create using a priority encoder over
// the slot kinds. A single result register sits between the channels; while
// it holds a beat that the receiver does not take, in_tready follows
// out_tready, so the block stalls without losing or repeating a beat.
// Reset (rst_n low, synchronous) empties every slot, makes every counter
// inactive and returns the check pointer to slot 0. Intervals are not reset
// and are defined once a create or set interval has written them.
`default_nettype none

module software_timer_task_table_top
  import stt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // interval_value[15:0], kind[17:16], target_id[27:18], zero[31:28]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // op[2:0]
  input  wire logic [OP_W-1:0]       in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // new_id[9:0], fire[10], fire_slot[14:11], status[16:15], zero[23:17]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  stt_cmd_t                cmd;
  logic [ID_W-1:0]         new_id;
  logic                    fire;
  logic [FIRE_SLOT_W-1:0]  fire_slot;
  logic [STATUS_W-1:0]     status;

  stt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  stt_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .op             (in_tuser),
    .interval_value (in_tdata[15:0]),
    .kind           (in_tdata[17:16]),
    .target_id      (in_tdata[27:18]),
    .new_id         (new_id),
    .fire           (fire),
    .fire_slot      (fire_slot),
    .status         (status)
  );

  assign out_tdata = {7'd0, status, fire_slot, fire, new_id};

endmodule

`default_nettype wire

/* hw/rtl/stt_ctrl.sv */
`default_nettype none

module stt_ctrl
  import stt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output stt_cmd_t      cmd
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  // The result register may be refilled in the cycle its beat is taken.
  assign in_tready  = (state_r == ST_EMPTY) || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_FULL);
  assign cmd.exec   = accept;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EMPTY: begin
        if (accept) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (out_tready && !accept) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  a_no_exec_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !cmd.exec)
    else $error("operation executed over a stalled result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

/* hw/rtl/stt_datapath.sv */
`default_nettype none

module stt_datapath
  import stt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire stt_cmd_t                 cmd,
  input  wire logic [OP_W-1:0]          op,
  input  wire logic [IVAL_W-1:0]        interval_value,
  input  wire logic [KIND_W-1:0]        kind,
  input  wire logic [ID_W-1:0]          target_id,
  output logic [ID_W-1:0]               new_id,
  output logic                          fire,
  output logic [FIRE_SLOT_W-1:0]        fire_slot,
  output logic [STATUS_W-1:0]           status
);

  // A counter of -1 is kept as a cleared active bit.
  logic [NUM_TASKS-1:0]     act_r, act_nxt;
  logic [INTERVAL_BITS-1:0] cnt_r   [NUM_TASKS];
  logic [INTERVAL_BITS-1:0] cnt_nxt [NUM_TASKS];
  logic [KIND_W-1:0]        kind_r  [NUM_TASKS];
  logic [KIND_W-1:0]        kind_nxt[NUM_TASKS];
  logic [INTERVAL_BITS-1:0] period_r[NUM_TASKS];
  logic [SLOT_W-1:0]        ptr_r, ptr_nxt;

  logic                     per_we;
  logic [SLOT_W-1:0]        per_addr;

  logic [ID_W-1:0]          new_id_r, new_id_nxt;
  logic                     fire_r, fire_nxt;
  logic [FIRE_SLOT_W-1:0]   fire_slot_r, fire_slot_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;

  logic [INTERVAL_BITS-1:0] ival;
  logic                     free_found;
  logic [SLOT_W-1:0]        free_slot;
  logic [ID_CMP_W-1:0]      tid_ext, tid_off;
  logic                     tid_ok;
  logic [SLOT_W-1:0]        tid_slot;
  logic                     hit;
  logic [31:0]              slot_wide;

  assign ival     = INTERVAL_BITS'(interval_value);
  assign tid_ext  = ID_CMP_W'(target_id);
  assign tid_ok   = (tid_ext >= ID_BASE) && (tid_ext < ID_LIMIT);
  assign tid_off  = tid_ext - ID_BASE;
  assign tid_slot = tid_off[SLOT_W-1:0];
  assign hit      = act_r[ptr_r] && (cnt_r[ptr_r] == '0);

  // Lowest slot whose kind is empty.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (!free_found && kind_r[i] == KIND_EMPTY) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    act_nxt       = act_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    ptr_nxt       = ptr_r;
    per_we        = 1'b0;
    per_addr      = free_slot;
    new_id_nxt    = '0;
    fire_nxt      = 1'b0;
    fire_slot_nxt = '0;
    status_nxt    = STATUS_OK;
    slot_wide     = 32'(ptr_r);

    case (op)
      OP_CLEAR: begin
        act_nxt = '0;
        for (int i = 0; i < NUM_TASKS; i++) kind_nxt[i] = KIND_EMPTY;
      end
      OP_CREATE: begin
        if (free_found) begin
          kind_nxt[free_slot] = kind;
          cnt_nxt[free_slot]  = ival;
          act_nxt[free_slot]  = 1'b1;
          per_we              = 1'b1;
          per_addr            = free_slot;
          new_id_nxt          = ID_W'(ID_BASE + ID_CMP_W'(free_slot));
        end else begin
          status_nxt = STATUS_FULL;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (act_r[i] && cnt_r[i] != '0) cnt_nxt[i] = cnt_r[i] - 1'b1;
        end
      end
      OP_CHECK: begin
        if (hit) begin
          fire_nxt      = 1'b1;
          fire_slot_nxt = slot_wide[FIRE_SLOT_W-1:0];
          case (kind_r[ptr_r])
            KIND_ONE_SHOT:  act_nxt[ptr_r] = 1'b0;
            KIND_CYCLIC:    cnt_nxt[ptr_r] = period_r[ptr_r];
            KIND_ONCE_KILL: begin
              act_nxt[ptr_r]  = 1'b0;
              kind_nxt[ptr_r] = KIND_EMPTY;
            end
            default: ;  // an unknown kind leaves the counter at zero
          endcase
        end
        ptr_nxt = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
      end
      OP_SET: begin
        if (tid_ok) begin
          cnt_nxt[tid_slot] = ival;
          act_nxt[tid_slot] = 1'b1;
          per_we            = 1'b1;
          per_addr          = tid_slot;
        end else begin
          status_nxt = STATUS_BAD_ID;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      ptr_r <= '0;
      for (int i = 0; i < NUM_TASKS; i++) kind_r[i] <= KIND_EMPTY;
    end else if (cmd.exec) begin
      act_r  <= act_nxt;
      ptr_r  <= ptr_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cnt_r       <= cnt_nxt;
      new_id_r    <= new_id_nxt;
      fire_r      <= fire_nxt;
      fire_slot_r <= fire_slot_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && per_we) period_r[per_addr] <= ival;
  end

  assign new_id    = new_id_r;
  assign fire      = fire_r;
  assign fire_slot = fire_slot_r;
  assign status    = status_r;

endmodule

`default_nettype wire

/* sim/task_table_checker.sv */
`timescale 1ns / 1ps

module task_table_checker
  import stt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [OP_W-1:0]       in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  output int                         errors,
  output int                         pending
);

  // Result beat layout, lowest field last.
  typedef struct packed {
    logic [6:0]             pad;
    logic [STATUS_W-1:0]    status;
    logic [FIRE_SLOT_W-1:0] fire_slot;
    logic                   fire;
    logic [ID_W-1:0]        new_id;
  } sched_result_t;

  logic [KIND_W-1:0] kind_tab   [NUM_TASKS];
  int                count_tab  [NUM_TASKS];
  logic [IVAL_W-1:0] period_tab [NUM_TASKS];
  int                check_ptr;

  sched_result_t predicted_results[$];
  sched_result_t want, got;

  initial begin
    errors    = 0;
    pending   = 0;
    check_ptr = 0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      kind_tab[i]   = KIND_EMPTY;
      count_tab[i]  = -1;
      period_tab[i] = '0;
    end
  end

  // Applies one operation to the shadow table and returns the reply it should produce.
  function automatic sched_result_t apply_operation(logic [OP_W-1:0] op,
                                                    logic [IVAL_W-1:0] ival,
                                                    logic [KIND_W-1:0] kind,
                                                    logic [ID_W-1:0] tid);
    sched_result_t r;
    bit            placed;
    int            s;
    r      = '0;
    placed = 1'b0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          count_tab[i] = -1;
          kind_tab[i]  = KIND_EMPTY;
        end
      end
      OP_CREATE: begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (!placed && kind_tab[i] == KIND_EMPTY) begin
            kind_tab[i]   = kind;
            period_tab[i] = ival;
            count_tab[i]  = int'(ival);
            r.new_id      = ID_W'(int'(ID_BASE) + i);
            placed        = 1'b1;
          end
        end
        if (!placed) r.status = STATUS_FULL;
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_TASKS; i++)
          if (count_tab[i] > 0) count_tab[i]--;
      end
      OP_CHECK: begin
        s = check_ptr;
        if (count_tab[s] == 0) begin
          r.fire      = 1'b1;
          r.fire_slot = FIRE_SLOT_W'(s);
          case (kind_tab[s])
            KIND_ONE_SHOT: count_tab[s] = -1;
            KIND_CYCLIC:   count_tab[s] = int'(period_tab[s]);
            KIND_ONCE_KILL: begin
              count_tab[s] = -1;
              kind_tab[s]  = KIND_EMPTY;
            end
            default: ;  // an unknown kind leaves the counter parked at zero
          endcase
        end
        check_ptr = (s == NUM_TASKS - 1) ? 0 : s + 1;
      end
      OP_SET: begin
        if (int'(tid) >= int'(ID_BASE) && int'(tid) < int'(ID_LIMIT)) begin
          s             = int'(tid) - int'(ID_BASE);
          period_tab[s] = ival;
          count_tab[s]  = int'(ival);
        end else begin
          r.status = STATUS_BAD_ID;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // The reply beat is checked before the new operation is predicted, as it always
  // belongs to an earlier operation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = sched_result_t'(out_tdata);
        if (predicted_results.size() == 0) begin
          $error("result beat with no operation outstanding: %h", out_tdata);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          if (got.new_id !== want.new_id) begin
            $error("new_id: expected %0d, got %0d", want.new_id, got.new_id);
            errors++;
          end
          if (got.fire !== want.fire) begin
            $error("fire: expected %0d, got %0d", want.fire, got.fire);
            errors++;
          end
          if (got.fire_slot !== want.fire_slot) begin
            $error("fire_slot: expected %0d, got %0d", want.fire_slot, got.fire_slot);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        predicted_results.push_back(apply_operation(in_tuser, in_tdata[15:0],
                                                    in_tdata[17:16], in_tdata[27:18]));
      pending = predicted_results.size();
    end
  end

endmodule

/* sim/software_timer_task_table_top_tb.sv */
`timescale 1ns / 1ps

module software_timer_task_table_top_tb;
  import stt_pkg::*;

  localparam int RANDOM_OPS = 1400;
  localparam int CALM_TAIL  = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    errors;
  int                    pending;

  // Shared between the sender and the receiver, except ops_sent (sender only).
  int idle_pct;
  bit hold_req;
  int ops_sent;

  software_timer_task_table_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  task_table_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offers one operation, possibly after an idle burst, and waits until it is taken.
  task automatic issue_op(logic [OP_W-1:0] op, logic [IVAL_W-1:0] ival,
                          logic [KIND_W-1:0] kind, logic [ID_W-1:0] tid);
    int gap;
    gap = (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, tid, kind, ival};
    do @(posedge clk); while (!in_tready);
    ops_sent++;
  endtask

  // Mostly short intervals so that counters actually run out.
  function automatic logic [IVAL_W-1:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return IVAL_W'($urandom_range(0, 6));
    if (r < 90) return IVAL_W'($urandom_range(7, 40));
    return IVAL_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    return ($urandom_range(0, 15) == 0) ? KIND_EMPTY : KIND_W'($urandom_range(1, 3));
  endfunction

  task automatic random_op(int create_pct);
    int                r;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   tid;
    r   = $urandom_range(0, 99);
    tid = ($urandom_range(0, 4) != 0) ? ID_W'($urandom_range(1000, 1015))
                                      : ID_W'($urandom_range(0, 1015));
    if (r < create_pct) begin
      op = OP_CREATE;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 32)      op = OP_TICK;
      else if (r < 82) op = OP_CHECK;
      else if (r < 95) op = OP_SET;
      else if (r < 96) op = OP_CLEAR;
      else             op = OP_W'($urandom_range(5, 7));
    end
    issue_op(op, pick_interval(), pick_kind(), tid);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (299) @(negedge clk);
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int  len;
    int  create_pct;
    bit  hold_done;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    idle_pct  = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    ops_sent  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: unused codes, each non-cyclic kind firing, bad ids and extreme intervals.
    issue_op(3'd5, 16'hFFFF, 2'd3, 10'd1015);
    issue_op(3'd6, 16'h0000, 2'd0, 10'd0);
    issue_op(3'd7, 16'hAAAA, 2'd1, 10'd1000);
    issue_op(OP_CREATE, 16'd0, KIND_ONE_SHOT, 10'd0);
    issue_op(OP_CREATE, 16'd1, KIND_CYCLIC, 10'd0);
    issue_op(OP_CREATE, 16'd0, KIND_ONCE_KILL, 10'd0);
    issue_op(OP_CREATE, 16'd0, KIND_EMPTY, 10'd0);
    repeat (4) issue_op(OP_CHECK, 16'h5555, 2'd3, 10'd1023 - 10'd8);
    issue_op(OP_TICK, 16'd0, 2'd0, 10'd0);
    issue_op(OP_SET, 16'd7, KIND_CYCLIC, 10'd999);
    issue_op(OP_SET, 16'd7, KIND_CYCLIC, 10'd0);
    issue_op(OP_SET, 16'hFFFF, KIND_CYCLIC, 10'd1015);
    issue_op(OP_SET, 16'd0, KIND_CYCLIC, 10'd1001);
    issue_op(OP_CREATE, 16'hFFFF, KIND_ONCE_KILL, 10'd0);
    issue_op(OP_TICK, 16'd0, 2'd0, 10'd0);
    issue_op(OP_CHECK, 16'd0, 2'd0, 10'd0);
    issue_op(OP_CLEAR, 16'hFFFF, 2'd3, 10'd1015);
    issue_op(OP_CHECK, 16'd0, 2'd0, 10'd0);
    issue_op(OP_CREATE, 16'h8000, KIND_CYCLIC, 10'd0);

    // Random episodes: some fill the table quickly, others mostly tick and check.
    while (ops_sent < RANDOM_OPS) begin
      if (ops_sent > RANDOM_OPS - CALM_TAIL) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        issue_op(OP_CLEAR, pick_interval(), pick_kind(), ID_W'($urandom_range(0, 1015)));
      create_pct = $urandom_range(0, 1) ? 45 : 12;
      len        = $urandom_range(20, 80);
      // Long receiver hold-off while the sender keeps offering.
      if (!hold_done && ops_sent > 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      repeat (len) random_op(create_pct);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
